@@ rtl/core/stl_pkg.sv @@
// Shared types and constants for the token lexer: token kinds, lexer modes,
// keyword table, the result-plan handoff struct and the m_tdata field layout.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package stl_pkg;

    // Identifier storage and per-character result cap
    localparam int MAX_IDENT_LEN = 31;
    localparam int MAX_RESULTS   = 33;
    localparam int LEN_W         = $clog2(MAX_IDENT_LEN + 1);
    localparam int IDX_W         = $clog2(MAX_IDENT_LEN);

    // Field widths
    localparam int KIND_W  = 5;
    localparam int VALUE_W = 64;
    localparam int POS_W   = 16;
    localparam int CHAR_W  = 8;
    localparam int CNT_W   = 7;

    localparam logic [POS_W-1:0] POS_MAX = '1;

    // Token kinds
    localparam logic [KIND_W-1:0] K_END     = 5'd0;
    localparam logic [KIND_W-1:0] K_BAD     = 5'd1;
    localparam logic [KIND_W-1:0] K_KW_BASE = 5'd2;
    localparam logic [KIND_W-1:0] K_LBRACE  = 5'd9;
    localparam logic [KIND_W-1:0] K_RBRACE  = 5'd10;
    localparam logic [KIND_W-1:0] K_LPAREN  = 5'd11;
    localparam logic [KIND_W-1:0] K_RPAREN  = 5'd12;
    localparam logic [KIND_W-1:0] K_COLON   = 5'd13;
    localparam logic [KIND_W-1:0] K_SEMI    = 5'd14;
    localparam logic [KIND_W-1:0] K_STAR    = 5'd15;
    localparam logic [KIND_W-1:0] K_IDENT   = 5'd16;
    localparam logic [KIND_W-1:0] K_NUMBER  = 5'd17;

    typedef enum logic [3:0] {
        M_IDLE,
        M_SLASH,
        M_BLOCK,
        M_BLOCK_STAR,
        M_LINE,
        M_IDENT,
        M_ZERO,
        M_HEX,
        M_BIN,
        M_OCT,
        M_DEC
    } lex_mode_t;

    // Keywords, left aligned: character i sits at byte KW_MAX_LEN-1-i
    localparam int NUM_KW     = 7;
    localparam int KW_MAX_LEN = 6;
    localparam logic [8*KW_MAX_LEN-1:0] KW_TEXT [NUM_KW] = '{
        {"start", 8'h00},
        "header",
        "fields",
        "length",
        {"next", 16'h0000},
        "select",
        {"case", 16'h0000}
    };
    localparam int KW_LEN [NUM_KW] = '{5, 6, 6, 6, 4, 6, 4};

    // Results caused by one character: token A (single token or an
    // identifier run), then optional token B (from relexing the character).
    typedef struct packed {
        logic                a_valid;
        logic                a_run;
        logic [KIND_W-1:0]   a_kind;
        logic [VALUE_W-1:0]  a_value;
        logic [POS_W-1:0]    a_row;
        logic [POS_W-1:0]    a_col;
        logic [LEN_W-1:0]    run_len;
        logic [LEN_W-1:0]    run_end;
        logic [LEN_W-1:0]    run_idx;
        logic                b_valid;
        logic [KIND_W-1:0]   b_kind;
        logic [POS_W-1:0]    b_row;
        logic [POS_W-1:0]    b_col;
    } plan_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] value;
        logic [POS_W-1:0]   row;
        logic [POS_W-1:0]   col;
        logic [CHAR_W-1:0]  ch;
        logic               done;
        logic               last;
    } result_t;

    // m_tdata layout
    localparam int TD_KIND_LO  = 0;
    localparam int TD_VALUE_LO = TD_KIND_LO + KIND_W;
    localparam int TD_ROW_LO   = TD_VALUE_LO + VALUE_W;
    localparam int TD_COL_LO   = TD_ROW_LO + POS_W;
    localparam int TD_CHAR_LO  = TD_COL_LO + POS_W;
    localparam int TD_LAST_BIT = TD_CHAR_LO + CHAR_W;
    localparam int TD_USED     = TD_LAST_BIT + 1;
    localparam int TD_W        = ((TD_USED + 7) / 8) * 8;

endpackage

`default_nettype wire

@@ rtl/core/stl_lex_core.sv @@
// Lexer state machine: position counters, identifier store, number
// accumulator, and the per-character result plan.
// Depends on stl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stl_lex_core import stl_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_fire,
    input  logic [CHAR_W-1:0] text_char,
    input  logic [IDX_W-1:0]  rd_idx,
    output logic [CHAR_W-1:0] rd_data,
    output logic [CHAR_W-1:0] rd_first,
    output plan_t             plan
);

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_SLASH = "/";
    localparam logic [7:0] CH_STAR  = "*";

    lex_mode_t          mode_reg, mode_next;
    logic [CHAR_W-1:0]  store_reg [MAX_IDENT_LEN];
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [VALUE_W-1:0] acc_reg, acc_next;
    logic               ovf_reg, ovf_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [POS_W-1:0]   line_reg, line_next, col_reg, col_next;
    logic [POS_W-1:0]   srow_reg, srow_next, scol_reg, scol_next;

    logic [CHAR_W-1:0]  c;
    logic               is_alpha, is_digit, is_oct, is_hexalpha, is_alnum;

    // Idle-mode decode of the current character
    lex_mode_t          idl_mode;
    logic               idl_tok, idl_end, idl_ident, idl_zero, idl_dec;
    logic [KIND_W-1:0]  idl_kind;

    // Digit accumulate
    logic [3:0]         dig_val;
    logic               dig_ok;
    logic [VALUE_W+3:0] acc_wide, acc_shift, acc_sum;
    logic [VALUE_W-1:0] add_acc;
    logic               add_ovf;
    logic [CNT_W-1:0]   add_cnt, dig_limit;
    logic               at_limit;
    logic [VALUE_W-1:0] num_old, num_new;

    logic [POS_W-1:0]   line_upd, col_upd;
    logic [POS_W:0]     tab_sum;

    logic               kw_hit;
    logic [KIND_W-1:0]  kw_kind;
    logic [LEN_W-1:0]   len_inc;

    logic               store_we;
    logic [IDX_W-1:0]   store_wa;

    logic               run_idle, a_set, a_run, a_now, a_end;
    logic [KIND_W-1:0]  a_kind;
    logic [VALUE_W-1:0] a_val;
    logic [LEN_W-1:0]   a_len;

    assign c           = text_char;
    assign is_alpha    = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    assign is_digit    = (c >= "0" && c <= "9");
    assign is_oct      = (c >= "0" && c <= "7");
    assign is_hexalpha = ((c | 8'h20) >= "a") && ((c | 8'h20) <= "f");
    assign is_alnum    = is_alpha || is_digit;
    assign len_inc     = len_reg + 1'b1;

    assign rd_data  = store_reg[rd_idx];
    assign rd_first = store_reg[0];

    // What a character does when seen between tokens
    always_comb begin
        idl_mode  = M_IDLE;
        idl_tok   = 1'b0;
        idl_kind  = K_BAD;
        idl_end   = 1'b0;
        idl_ident = 1'b0;
        idl_zero  = 1'b0;
        idl_dec   = 1'b0;
        priority if (c == CH_SP || c == CH_TAB || c == CH_LF || c == CH_CR) begin
        end else if (c == CH_SLASH) begin
            idl_mode = M_SLASH;
        end else if (c == "{") begin
            idl_tok = 1'b1; idl_kind = K_LBRACE;
        end else if (c == "}") begin
            idl_tok = 1'b1; idl_kind = K_RBRACE;
        end else if (c == "(") begin
            idl_tok = 1'b1; idl_kind = K_LPAREN;
        end else if (c == ")") begin
            idl_tok = 1'b1; idl_kind = K_RPAREN;
        end else if (c == ":") begin
            idl_tok = 1'b1; idl_kind = K_COLON;
        end else if (c == ";") begin
            idl_tok = 1'b1; idl_kind = K_SEMI;
        end else if (c == CH_STAR) begin
            idl_tok = 1'b1; idl_kind = K_STAR;
        end else if (c == CH_NUL) begin
            idl_tok = 1'b1; idl_kind = K_END; idl_end = 1'b1;
        end else if (is_alpha) begin
            // store depth is at least 8, so one letter never fills it
            idl_mode = M_IDENT; idl_ident = 1'b1;
        end else if (c == "0") begin
            idl_mode = M_ZERO; idl_zero = 1'b1;
        end else if (is_digit) begin
            idl_mode = M_DEC; idl_dec = 1'b1;
        end else begin
            idl_tok = 1'b1; idl_kind = K_BAD;
        end
    end

    // Digit value and the multiply-add step
    always_comb begin
        dig_val = c[3:0];
        if (!is_digit) begin
            dig_val = c[3:0] + 4'd9;
        end
        unique case (mode_reg)
            M_HEX:          dig_ok = is_digit || is_hexalpha;
            M_BIN:          dig_ok = (c == "0") || (c == "1");
            M_ZERO, M_OCT:  dig_ok = is_oct;
            M_DEC:          dig_ok = is_digit;
            default:        dig_ok = 1'b0;
        endcase
    end

    always_comb begin
        acc_wide = {4'b0000, acc_reg};
        unique case (mode_reg)
            M_HEX: begin
                acc_shift = acc_wide << 4;
                dig_limit = CNT_W'(16);
            end
            M_BIN: begin
                acc_shift = acc_wide << 1;
                dig_limit = CNT_W'(64);
            end
            M_DEC: begin
                acc_shift = (acc_wide << 3) + (acc_wide << 1);
                dig_limit = CNT_W'(20);
            end
            default: begin
                acc_shift = acc_wide << 3;
                dig_limit = CNT_W'(22);
            end
        endcase
        acc_sum  = acc_shift + (VALUE_W+4)'(dig_val);
        add_acc  = acc_sum[VALUE_W-1:0];
        add_ovf  = ovf_reg | (|acc_sum[VALUE_W+3:VALUE_W]);
        add_cnt  = cnt_reg + 1'b1;
        at_limit = (add_cnt >= dig_limit);
        num_old  = ovf_reg ? '1 : acc_reg;
        num_new  = add_ovf ? '1 : add_acc;
    end

    // Position after taking this character
    always_comb begin
        line_upd = line_reg;
        col_upd  = col_reg;
        tab_sum  = {1'b0, col_reg[POS_W-1:3], 3'b111} + (POS_W+1)'(1);
        if (c == CH_LF) begin
            if (line_reg != POS_MAX) begin
                line_upd = line_reg + 1'b1;
            end
            col_upd = '0;
        end else if (c == CH_TAB) begin
            col_upd = tab_sum[POS_W] ? POS_MAX : tab_sum[POS_W-1:0];
        end else if (col_reg != POS_MAX) begin
            col_upd = col_reg + 1'b1;
        end
    end

    // Keyword lookup on the stored identifier
    always_comb begin
        logic match;
        kw_hit  = 1'b0;
        kw_kind = K_IDENT;
        for (int k = NUM_KW - 1; k >= 0; k--) begin
            match = (int'(len_reg) == KW_LEN[k]);
            for (int i = 0; i < KW_MAX_LEN; i++) begin
                if (i < KW_LEN[k] &&
                    store_reg[i] != KW_TEXT[k][8*(KW_MAX_LEN-1-i) +: 8]) begin
                    match = 1'b0;
                end
            end
            if (match) begin
                kw_hit  = 1'b1;
                kw_kind = K_KW_BASE + KIND_W'(k);
            end
        end
    end

    // Next mode
    always_comb begin
        unique case (mode_reg)
            M_IDLE:  mode_next = idl_mode;
            M_SLASH: begin
                if (c == CH_STAR)       mode_next = M_BLOCK;
                else if (c == CH_SLASH) mode_next = M_LINE;
                else                    mode_next = idl_mode;
            end
            M_BLOCK, M_BLOCK_STAR: begin
                if (c == CH_NUL)       mode_next = M_IDLE;
                else if (c == CH_STAR) mode_next = M_BLOCK_STAR;
                else if (c == CH_SLASH && mode_reg == M_BLOCK_STAR) mode_next = M_IDLE;
                else                   mode_next = M_BLOCK;
            end
            M_LINE: begin
                mode_next = (c == CH_NUL || c == CH_LF) ? M_IDLE : M_LINE;
            end
            M_IDENT: begin
                if (is_alnum) begin
                    mode_next = (int'(len_inc) >= MAX_IDENT_LEN) ? M_IDLE : M_IDENT;
                end else begin
                    mode_next = idl_mode;
                end
            end
            M_ZERO: begin
                if (c == "x" || c == "X")      mode_next = M_HEX;
                else if (c == "b" || c == "B") mode_next = M_BIN;
                else if (dig_ok)               mode_next = M_OCT;
                else                           mode_next = idl_mode;
            end
            M_HEX, M_BIN, M_OCT, M_DEC: begin
                if (dig_ok) mode_next = at_limit ? M_IDLE : mode_reg;
                else        mode_next = idl_mode;
            end
            default: mode_next = idl_mode;
        endcase
    end

    // Datapath updates and the result plan
    always_comb begin
        run_idle  = 1'b0;
        a_set     = 1'b0;
        a_run     = 1'b0;
        a_now     = 1'b0;
        a_end     = 1'b0;
        a_kind    = K_BAD;
        a_val     = '0;
        a_len     = '0;
        store_we  = 1'b0;
        store_wa  = '0;
        len_next  = len_reg;
        acc_next  = acc_reg;
        ovf_next  = ovf_reg;
        cnt_next  = cnt_reg;
        srow_next = srow_reg;
        scol_next = scol_reg;

        unique case (mode_reg)
            M_IDLE: run_idle = 1'b1;
            M_SLASH: begin
                if (c != CH_STAR && c != CH_SLASH) begin
                    a_set    = 1'b1;
                    a_kind   = K_BAD;
                    run_idle = 1'b1;
                end
            end
            M_BLOCK, M_BLOCK_STAR, M_LINE: begin
                if (c == CH_NUL) begin
                    a_set  = 1'b1;
                    a_kind = K_END;
                    a_now  = 1'b1;
                    a_end  = 1'b1;
                end
            end
            M_IDENT: begin
                if (is_alnum) begin
                    store_we = 1'b1;
                    store_wa = len_reg[IDX_W-1:0];
                    len_next = len_inc;
                    if (int'(len_inc) >= MAX_IDENT_LEN) begin
                        a_set = 1'b1;
                        a_run = 1'b1;
                        a_len = len_inc;
                    end
                end else begin
                    a_set    = 1'b1;
                    a_run    = !kw_hit;
                    a_kind   = kw_kind;
                    a_len    = len_reg;
                    run_idle = 1'b1;
                end
            end
            M_ZERO: begin
                if (dig_ok) begin
                    acc_next = add_acc;
                    ovf_next = add_ovf;
                    cnt_next = add_cnt;
                end else if (c != "x" && c != "X" && c != "b" && c != "B") begin
                    a_set    = 1'b1;
                    a_kind   = K_NUMBER;
                    a_val    = num_old;
                    run_idle = 1'b1;
                end
            end
            M_HEX, M_BIN, M_OCT, M_DEC: begin
                if (dig_ok) begin
                    acc_next = add_acc;
                    ovf_next = add_ovf;
                    cnt_next = add_cnt;
                    if (at_limit) begin
                        a_set  = 1'b1;
                        a_kind = K_NUMBER;
                        a_val  = num_new;
                    end
                end else begin
                    a_set    = 1'b1;
                    a_kind   = K_NUMBER;
                    a_val    = num_old;
                    run_idle = 1'b1;
                end
            end
            default: run_idle = 1'b1;
        endcase

        if (a_now || run_idle) begin
            srow_next = line_upd;
            scol_next = col_upd;
        end

        if (run_idle) begin
            if (idl_ident) begin
                store_we = 1'b1;
                store_wa = '0;
                len_next = LEN_W'(1);
            end
            if (idl_zero) begin
                acc_next = '0;
                ovf_next = 1'b0;
                cnt_next = '0;
            end
            if (idl_dec) begin
                acc_next = VALUE_W'(c[3:0]);
                ovf_next = 1'b0;
                cnt_next = CNT_W'(1);
            end
        end

        line_next = line_upd;
        col_next  = col_upd;
        if (a_end || (run_idle && idl_end)) begin
            line_next = POS_W'(1);
            col_next  = '0;
        end

        plan         = '0;
        plan.a_valid = a_set;
        plan.a_run   = a_run;
        plan.a_kind  = a_kind;
        plan.a_value = a_val;
        plan.a_row   = a_now ? line_upd : srow_reg;
        plan.a_col   = a_now ? col_upd : scol_reg;
        plan.run_len = a_len;
        plan.run_end = (int'(a_len) > MAX_RESULTS) ? LEN_W'(MAX_RESULTS - 1)
                                                   : a_len - 1'b1;
        plan.run_idx = '0;
        // a run that already fills the per-character cap drops the trailing token
        plan.b_valid = run_idle && idl_tok && !(a_run && int'(a_len) >= MAX_RESULTS);
        plan.b_kind  = idl_kind;
        plan.b_row   = line_upd;
        plan.b_col   = col_upd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= M_IDLE;
            len_reg  <= '0;
            acc_reg  <= '0;
            ovf_reg  <= 1'b0;
            cnt_reg  <= '0;
            line_reg <= POS_W'(1);
            col_reg  <= '0;
            srow_reg <= POS_W'(1);
            scol_reg <= '0;
        end else if (in_fire) begin
            mode_reg <= mode_next;
            len_reg  <= len_next;
            acc_reg  <= acc_next;
            ovf_reg  <= ovf_next;
            cnt_reg  <= cnt_next;
            line_reg <= line_next;
            col_reg  <= col_next;
            srow_reg <= srow_next;
            scol_reg <= scol_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire && store_we) begin
            store_reg[store_wa] <= c;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/stl_out_stage.sv @@
// Result sequencer: output register plus a pending-plan skid that walks
// identifier runs one character per beat. Depends on stl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stl_out_stage import stl_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_fire,
    input  plan_t             in_plan,
    input  logic [CHAR_W-1:0] rd_first,
    input  logic [CHAR_W-1:0] rd_data,
    output logic [IDX_W-1:0]  rd_idx,
    output logic              s_ready,
    input  logic              m_ready,
    output logic              m_valid,
    output result_t           m_beat
);

    plan_t   pend_reg, pend_next;
    logic    m_valid_reg, m_valid_next;
    result_t beat_reg, beat_next;
    logic    pend_busy, in_live, slot_free;

    function automatic result_t plan_head(input plan_t p, input logic [CHAR_W-1:0] ch);
        result_t r;
        r = '0;
        if (p.a_valid) begin
            r.kind  = p.a_run ? K_IDENT : p.a_kind;
            r.value = p.a_run ? '0 : p.a_value;
            r.row   = p.a_row;
            r.col   = p.a_col;
            r.ch    = p.a_run ? ch : '0;
            r.done  = p.a_run ? (LEN_W'(p.run_idx + 1'b1) == p.run_len) : 1'b1;
            r.last  = !p.b_valid && (!p.a_run || p.run_idx == p.run_end);
        end else begin
            r.kind = p.b_kind;
            r.row  = p.b_row;
            r.col  = p.b_col;
            r.done = 1'b1;
            r.last = 1'b1;
        end
        return r;
    endfunction

    function automatic plan_t plan_advance(input plan_t p);
        plan_t q;
        q = p;
        if (p.a_valid) begin
            if (p.a_run && p.run_idx != p.run_end) begin
                q.run_idx = p.run_idx + 1'b1;
            end else begin
                q.a_valid = 1'b0;
            end
        end else begin
            q.b_valid = 1'b0;
        end
        return q;
    endfunction

    assign pend_busy = pend_reg.a_valid || pend_reg.b_valid;
    assign in_live   = in_fire && (in_plan.a_valid || in_plan.b_valid);
    assign slot_free = !m_valid_reg || m_ready;
    assign s_ready   = !pend_busy;
    assign rd_idx    = pend_reg.run_idx[IDX_W-1:0];
    assign m_valid   = m_valid_reg;
    assign m_beat    = beat_reg;

    always_comb begin
        pend_next    = pend_reg;
        m_valid_next = m_valid_reg;
        beat_next    = beat_reg;
        priority if (pend_busy) begin
            if (slot_free) begin
                beat_next    = plan_head(pend_reg, rd_data);
                pend_next    = plan_advance(pend_reg);
                m_valid_next = 1'b1;
            end
        end else if (in_live) begin
            // a new run always starts at store entry 0
            if (slot_free) begin
                beat_next    = plan_head(in_plan, rd_first);
                pend_next    = plan_advance(in_plan);
                m_valid_next = 1'b1;
            end else begin
                pend_next = in_plan;
            end
        end else begin
            if (slot_free) begin
                m_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg      <= 1'b0;
            pend_reg.a_valid <= 1'b0;
            pend_reg.b_valid <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            pend_reg    <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        beat_reg <= beat_next;
    end

endmodule

`default_nettype wire

@@ rtl/core/spec_token_lexer.sv @@
// Top level of the streaming token lexer: lexer core and result sequencer.
// Depends on stl_pkg, stl_lex_core, stl_out_stage.
`timescale 1ns / 1ps
`default_nettype none

// One text character enters per s_ beat (0 ends the text) and tokens leave on
// the m_ side, each tagged with the row and column of its first character
// (rows from 1, tabs to the next multiple of 8, both saturating at 65535).
// A character that yields no result or a single result is taken back to back
// while the output is not stalled, and its result is registered in the output
// register. When one character closes a token and is itself a one-character
// token (for example "x;" or "12)"), two results leave one after the
// other and s_tready drops while the second waits in the pending plan. An
// identifier leaves as one beat per character, so a run holds s_tready low
// while it is walked out; keywords leave as one beat. The limit is the single
// output register, which moves one result per cycle unless m_tready stalls
// it. A number that does not fit in 64 bits reads as all ones. After an end
// token the position restarts at row 1, column 0. No clearing pass after reset.

module spec_token_lexer import stl_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [7:0]      s_tdata,   // [7:0] text_char
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [TD_W-1:0] m_tdata,   // [4:0] token_kind, [68:5] number_value,
                                       // [84:69] token_row, [100:85] token_column,
                                       // [108:101] ident_char, [109] run_last
    output logic            m_tlast    // token_done
);

    logic              in_fire;
    plan_t             plan;
    logic [IDX_W-1:0]  rd_idx;
    logic [CHAR_W-1:0] rd_data, rd_first;
    result_t           beat;

    assign in_fire = s_tvalid && s_tready;

    stl_lex_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .text_char (s_tdata),
        .rd_idx    (rd_idx),
        .rd_data   (rd_data),
        .rd_first  (rd_first),
        .plan      (plan)
    );

    stl_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_fire  (in_fire),
        .in_plan  (plan),
        .rd_first (rd_first),
        .rd_data  (rd_data),
        .rd_idx   (rd_idx),
        .s_ready  (s_tready),
        .m_ready  (m_tready),
        .m_valid  (m_tvalid),
        .m_beat   (beat)
    );

    assign m_tdata = {{(TD_W - TD_USED){1'b0}}, beat.last, beat.ch, beat.col, beat.row,
                      beat.value, beat.kind};
    assign m_tlast = beat.done;

endmodule

`default_nettype wire

@@ rtl/core/stl_checker.sv @@
// Port-level checks on the lexer result stream, bound to spec_token_lexer.
// Depends on stl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stl_checker import stl_pkg::*; (
    input logic            aclk,
    input logic            aresetn,
    input logic            m_tvalid,
    input logic            m_tready,
    input logic [TD_W-1:0] m_tdata,
    input logic            m_tlast
);

    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] value;
    logic [CHAR_W-1:0]  ch;

    assign kind  = m_tdata[TD_KIND_LO +: KIND_W];
    assign value = m_tdata[TD_VALUE_LO +: VALUE_W];
    assign ch    = m_tdata[TD_CHAR_LO +: CHAR_W];

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result beat changed while stalled");

    a_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> kind <= K_NUMBER)
        else $error("token kind out of range");

    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && kind != K_IDENT |-> m_tlast && ch == '0)
        else $error("non-identifier token split or carrying a character");

    a_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && kind != K_NUMBER |-> value == '0)
        else $error("value on a non-number token");

endmodule

bind spec_token_lexer stl_checker u_stl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for spec_token_lexer: text characters go in as beats and every
// token beat is checked against a lexer model kept inside the bench.
// Depends on stl_pkg and the spec_token_lexer RTL.

module tb_top;
    import stl_pkg::*;

    localparam int QUIET_LIMIT  = 4000;  // cycles without any beat before giving up
    localparam int TAIL_CYCLES  = 40;    // settle time after the last expected token
    localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
    localparam int RANDOM_CHARS = 120;
    localparam int POS_LIMIT    = 65535;

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_SP  = 8'h20;

    logic            aclk     = 1'b0;
    logic            aresetn  = 1'b0;
    logic            s_tvalid = 1'b0;
    logic            s_tready;
    logic [7:0]      s_tdata  = '0;    // [7:0] text_char
    logic            m_tvalid;
    logic            m_tready = 1'b0;
    logic [TD_W-1:0] m_tdata;          // kind, value, row, column, ident char, run_last
    logic            m_tlast;          // token_done

    spec_token_lexer uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Lexer model
    // ------------------------------------------------------------------
    string kw_names [NUM_KW] = '{"start", "header", "fields", "length", "next", "select", "case"};
    string LETTERS = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
    string ALNUM   = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    string HEXDIG  = "0123456789abcdefABCDEF";
    string PUNCT   = "{}():;*";
    string ODDS    = "@#$%&!?.,=+-<>[]~`'\"\\|^";

    lex_mode_t    lx_mode;
    logic [7:0]   id_buf [MAX_IDENT_LEN];
    int           id_len;
    logic [63:0]  acc;
    bit           ovf;
    int           ndig;
    int           line_no, col_no, tok_row, tok_col;
    result_t      step_q[$];
    result_t      expected_tokens[$];

    int           mismatches;
    int           beats_checked;
    int           chars_sent;
    int           lexed_chars;
    bit [31:0]    kinds_seen;
    bit           tx_idle_en;
    bit           rx_idle_en;
    bit           rx_hold_req;
    int           quiet_cycles;

    function automatic bit is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic int digit_of(input logic [7:0] c, input int base);
        int d;
        d = -1;
        if (is_digit(c))
            d = int'(c) - int'(8'h30);
        else if (base == 16 && c >= "a" && c <= "f")
            d = int'(c) - int'(8'h61) + 10;
        else if (base == 16 && c >= "A" && c <= "F")
            d = int'(c) - int'(8'h41) + 10;
        if (d >= base)
            d = -1;
        return d;
    endfunction

    function void emit_token(input logic [KIND_W-1:0] kind, input logic [63:0] value,
                             input logic [7:0] ch, input bit done);
        result_t r;
        if (step_q.size() < MAX_RESULTS) begin
            r.kind  = kind;
            r.value = value;
            r.row   = tok_row[15:0];
            r.col   = tok_col[15:0];
            r.ch    = ch;
            r.done  = done;
            r.last  = 1'b0;
            step_q.push_back(r);
        end
    endfunction

    function void mark_start();
        tok_row = line_no;
        tok_col = col_no;
    endfunction

    // end token also rewinds the position for the next text
    function void emit_end();
        emit_token(K_END, '0, '0, 1'b1);
        lx_mode = M_IDLE;
        line_no = 1;
        col_no  = 0;
    endfunction

    function void add_digit(input int base, input int d);
        if (acc > (64'hFFFF_FFFF_FFFF_FFFF - 64'(d)) / 64'(base))
            ovf = 1'b1;
        acc = acc * 64'(base) + 64'(d);
        ndig++;
    endfunction

    function void close_number();
        emit_token(K_NUMBER, ovf ? 64'hFFFF_FFFF_FFFF_FFFF : acc, '0, 1'b1);
        lx_mode = M_IDLE;
    endfunction

    // keyword -> single beat, otherwise one beat per stored character
    function void close_ident();
        int i, j;
        bit hit;
        for (i = 0; i < NUM_KW; i++) begin
            if (id_len == kw_names[i].len()) begin
                hit = 1'b1;
                for (j = 0; j < id_len; j++)
                    if (id_buf[j] != kw_names[i][j])
                        hit = 1'b0;
                if (hit) begin
                    emit_token(K_KW_BASE + KIND_W'(i), '0, '0, 1'b1);
                    lx_mode = M_IDLE;
                    return;
                end
            end
        end
        for (i = 0; i < id_len && i < MAX_IDENT_LEN; i++)
            emit_token(K_IDENT, '0, id_buf[i], (i + 1 == id_len));
        lx_mode = M_IDLE;
    endfunction

    function void reset_lexer_model();
        lx_mode = M_IDLE;
        id_len  = 0;
        acc     = '0;
        ovf     = 1'b0;
        ndig    = 0;
        line_no = 1;
        col_no  = 0;
        tok_row = 1;
        tok_col = 0;
        expected_tokens.delete();
    endfunction

    // Advance the model by one accepted character and queue the tokens it yields.
    function void lex_char(input logic [7:0] c);
        bit again;
        int d, base, limit;
        step_q.delete();

        if (c == CH_LF) begin
            if (line_no < POS_LIMIT)
                line_no++;
            col_no = 0;
        end else if (c == CH_TAB) begin
            col_no += 8 - col_no % 8;
            if (col_no > POS_LIMIT)
                col_no = POS_LIMIT;
        end else if (col_no < POS_LIMIT) begin
            col_no++;
        end

        do begin
            again = 1'b0;
            case (lx_mode)
                M_IDLE: begin
                    mark_start();
                    if (c == CH_SP || c == CH_TAB || c == CH_LF || c == CH_CR) begin
                        // blank, position already advanced
                    end else if (c == "/") begin
                        lx_mode = M_SLASH;
                    end else if (c == "{") begin
                        emit_token(K_LBRACE, '0, '0, 1'b1);
                    end else if (c == "}") begin
                        emit_token(K_RBRACE, '0, '0, 1'b1);
                    end else if (c == "(") begin
                        emit_token(K_LPAREN, '0, '0, 1'b1);
                    end else if (c == ")") begin
                        emit_token(K_RPAREN, '0, '0, 1'b1);
                    end else if (c == ":") begin
                        emit_token(K_COLON, '0, '0, 1'b1);
                    end else if (c == ";") begin
                        emit_token(K_SEMI, '0, '0, 1'b1);
                    end else if (c == "*") begin
                        emit_token(K_STAR, '0, '0, 1'b1);
                    end else if (c == CH_NUL) begin
                        emit_end();
                    end else if (is_letter(c)) begin
                        id_buf[0] = c;
                        id_len    = 1;
                        lx_mode   = M_IDENT;
                        if (id_len >= MAX_IDENT_LEN)
                            close_ident();
                    end else if (c == "0") begin
                        acc     = '0;
                        ovf     = 1'b0;
                        ndig    = 0;
                        lx_mode = M_ZERO;
                    end else if (is_digit(c)) begin
                        acc     = 64'(digit_of(c, 10));
                        ovf     = 1'b0;
                        ndig    = 1;
                        lx_mode = M_DEC;
                    end else begin
                        emit_token(K_BAD, '0, '0, 1'b1);
                    end
                end
                M_SLASH: begin
                    if (c == "*") begin
                        lx_mode = M_BLOCK;
                    end else if (c == "/") begin
                        lx_mode = M_LINE;
                    end else begin
                        // lone slash is bad, the character is lexed again
                        emit_token(K_BAD, '0, '0, 1'b1);
                        lx_mode = M_IDLE;
                        again   = 1'b1;
                    end
                end
                M_BLOCK, M_BLOCK_STAR: begin
                    if (c == CH_NUL) begin
                        mark_start();
                        emit_end();
                    end else if (c == "*") begin
                        lx_mode = M_BLOCK_STAR;
                    end else if (c == "/" && lx_mode == M_BLOCK_STAR) begin
                        lx_mode = M_IDLE;
                    end else begin
                        lx_mode = M_BLOCK;
                    end
                end
                M_LINE: begin
                    if (c == CH_NUL) begin
                        mark_start();
                        emit_end();
                    end else if (c == CH_LF) begin
                        lx_mode = M_IDLE;
                    end
                end
                M_IDENT: begin
                    if (is_letter(c) || is_digit(c)) begin
                        if (id_len < MAX_IDENT_LEN)
                            id_buf[id_len] = c;
                        id_len++;
                        if (id_len >= MAX_IDENT_LEN)
                            close_ident();
                    end else begin
                        close_ident();
                        again = 1'b1;
                    end
                end
                M_ZERO: begin
                    if (c == "x" || c == "X") begin
                        lx_mode = M_HEX;
                    end else if (c == "b" || c == "B") begin
                        lx_mode = M_BIN;
                    end else if (c >= "0" && c <= "7") begin
                        add_digit(8, digit_of(c, 8));
                        lx_mode = M_OCT;
                    end else begin
                        close_number();
                        again = 1'b1;
                    end
                end
                M_HEX, M_BIN, M_OCT, M_DEC: begin
                    base  = (lx_mode == M_HEX) ? 16 : (lx_mode == M_BIN) ? 2 :
                            (lx_mode == M_OCT) ? 8 : 10;
                    limit = (lx_mode == M_HEX) ? 16 : (lx_mode == M_BIN) ? 64 :
                            (lx_mode == M_OCT) ? 22 : 20;
                    d = digit_of(c, base);
                    if (d >= 0) begin
                        add_digit(base, d);
                        if (ndig >= limit)
                            close_number();
                    end else begin
                        close_number();
                        again = 1'b1;
                    end
                end
                default: begin
                    lx_mode = M_IDLE;
                    again   = 1'b1;
                end
            endcase
        end while (again);

        if (step_q.size() > 0)
            step_q[step_q.size() - 1].last = 1'b1;
        foreach (step_q[i])
            expected_tokens.push_back(step_q[i]);
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task report_mismatch(input string field, input logic [63:0] got_v,
                         input logic [63:0] want_v);
        mismatches++;
        if (mismatches <= 100)
            $display("[%0t] MISMATCH beat %0d %s: got %0h, expected %0h",
                     $realtime, beats_checked, field, got_v, want_v);
    endtask

    task check_token();
        result_t got, want;
        got.kind  = m_tdata[TD_KIND_LO +: KIND_W];
        got.value = m_tdata[TD_VALUE_LO +: VALUE_W];
        got.row   = m_tdata[TD_ROW_LO +: POS_W];
        got.col   = m_tdata[TD_COL_LO +: POS_W];
        got.ch    = m_tdata[TD_CHAR_LO +: CHAR_W];
        got.last  = m_tdata[TD_LAST_BIT];
        got.done  = m_tlast;
        beats_checked++;
        if (got.kind < 32)
            kinds_seen[got.kind] = 1'b1;
        if (expected_tokens.size() == 0) begin
            report_mismatch("token with nothing expected, kind", 64'(got.kind), '0);
        end else begin
            want = expected_tokens.pop_front();
            if (got.kind !== want.kind)
                report_mismatch("token_kind", 64'(got.kind), 64'(want.kind));
            if (got.value !== want.value)
                report_mismatch("number_value", got.value, want.value);
            if (got.row !== want.row)
                report_mismatch("token_row", 64'(got.row), 64'(want.row));
            if (got.col !== want.col)
                report_mismatch("token_column", 64'(got.col), 64'(want.col));
            if (got.ch !== want.ch)
                report_mismatch("ident_char", 64'(got.ch), 64'(want.ch));
            if (got.done !== want.done)
                report_mismatch("token_done", 64'(got.done), 64'(want.done));
            if (got.last !== want.last)
                report_mismatch("run_last", 64'(got.last), 64'(want.last));
        end
    endtask

    // both sides sampled at the edge, input predicted before output is checked
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                lex_char(s_tdata);
            if (m_tvalid && m_tready)
                check_token();
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Watchdog: %0d cycles without a beat, %0d tokens outstanding",
                         quiet_cycles, expected_tokens.size());
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stall bursts plus an on-request long hold-off
    // ------------------------------------------------------------------
    initial begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        forever begin
            @(posedge aclk);
            if (rx_hold_req) begin
                hold_left   = HOLD_CYCLES;
                rx_hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (aresetn && rx_idle_en && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 19) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= aresetn;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------
    // Called at a rising edge; returns at the edge where the beat was taken.
    // tvalid stays high so a following call can go back to back.
    task automatic send_char(input logic [7:0] c);
        int gap;
        if (tx_idle_en && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 19);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
        chars_sent++;
        if (c != CH_SP && c != CH_TAB && c != CH_LF && c != CH_CR)
            lexed_chars++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    // one edge first so the last accepted character is already predicted
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_tokens.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [7:0] pick_char(input string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    // mostly short, now and then around a length limit
    function automatic int pick_len(input int lo_s, input int hi_s, input int lo_l, input int hi_l);
        if ($urandom_range(0, 4) == 0)
            return $urandom_range(lo_l, hi_l);
        return $urandom_range(lo_s, hi_s);
    endfunction

    task automatic send_ident();
        int n;
        n = pick_len(1, 8, 29, 40);
        send_char(pick_char(LETTERS));
        repeat (n - 1) send_char(pick_char(ALNUM));
    endtask

    task automatic send_number();
        int n;
        case ($urandom_range(0, 3))
            0: begin
                n = pick_len(1, 6, 18, 23);
                send_char(pick_char("123456789"));
                repeat (n - 1) send_char(pick_char("0123456789"));
            end
            1: begin
                n = pick_len(0, 5, 14, 18);
                send_char("0");
                send_char(pick_char("xX"));
                repeat (n) send_char(pick_char(HEXDIG));
            end
            2: begin
                n = pick_len(0, 8, 62, 66);
                send_char("0");
                send_char(pick_char("bB"));
                repeat (n) send_char(pick_char("01"));
            end
            default: begin
                // no digits after the 0 gives a lone zero
                n = pick_len(0, 4, 20, 24);
                send_char("0");
                repeat (n) send_char(pick_char("01234567"));
            end
        endcase
    endtask

    task automatic send_comment();
        int n;
        n = $urandom_range(0, 12);
        if ($urandom_range(0, 1) == 0) begin
            send_text("/*");
            repeat (n) begin
                if ($urandom_range(0, 3) == 0)
                    send_char(pick_char("*/"));
                else
                    send_char(8'($urandom_range(1, 255)));
            end
            if ($urandom_range(0, 19) == 0)
                send_char(CH_NUL);      // text ends inside the comment
            else
                send_text("*/");
        end else begin
            send_text("//");
            repeat (n) send_char(8'($urandom_range(1, 255)));
            if ($urandom_range(0, 19) == 0)
                send_char(CH_NUL);
            else
                send_char(CH_LF);
        end
    endtask

    task automatic send_separator();
        case ($urandom_range(0, 9))
            0, 1, 2: send_char(CH_SP);
            3:       send_char(CH_TAB);
            4:       send_char(CH_LF);
            5:       begin send_char(CH_CR); send_char(CH_LF); end
            default: ;  // tokens run together
        endcase
    endtask

    task automatic send_random_token();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20)
            send_text(kw_names[$urandom_range(0, NUM_KW - 1)]);
        else if (r < 35)
            send_ident();
        else if (r < 55)
            send_number();
        else if (r < 72)
            send_char(pick_char(PUNCT));
        else if (r < 80)
            send_comment();
        else if (r < 84)
            send_char("/");
        else if (r < 90)
            send_char(($urandom_range(0, 1) == 0) ? 8'($urandom_range(128, 255)) : pick_char(ODDS));
        else if (r < 93)
            send_char(CH_NUL);
        else
            send_char(8'($urandom_range(0, 255)));
        send_separator();
    endtask

    task automatic send_random_text(input int n_chars);
        int stop_at;
        stop_at = lexed_chars + n_chars;
        while (lexed_chars < stop_at)
            send_random_token();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_punctuation();
        send_text("{}():;*");
    endtask

    // lone zero, hex and binary prefixes with no digits, short octal
    task automatic test_number_edges();
        send_text("0 0x;0b)07 ");
    endtask

    // lone slash, high codes and a stray symbol give bad tokens
    task automatic test_slash_and_bad();
        send_text("/a");
        send_char(8'hFF);
        send_char(8'h80);
        send_char("@");
        send_char(CH_LF);
    endtask

    task automatic test_tab_column();
        send_char(CH_TAB);
        send_char("q");
        send_char(CH_TAB);
        send_text("1;");
    endtask

    task automatic test_end_in_comment();
        send_text("/*x");
        send_char(CH_NUL);
        send_text("//y");
        send_char(CH_NUL);
        send_char(CH_NUL);
    endtask

    task automatic test_random_text();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        send_random_text(RANDOM_CHARS);
    endtask

    // receiver holds off while identifiers and punctuation keep coming, so input backs up
    task automatic test_output_backpressure();
        tx_idle_en  = 1'b0;
        rx_hold_req = 1'b1;
        repeat (8) begin
            send_ident();
            send_char(pick_char(PUNCT));
        end
        tx_idle_en = 1'b1;
    endtask

    task automatic test_drain_pause();
        repeat (10) send_random_token();
        wait_drained();
        repeat (10) send_random_token();
    endtask

    task automatic test_tail_no_idle();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        send_random_text(60);
    endtask

    initial begin
        mismatches    = 0;
        beats_checked = 0;
        chars_sent    = 0;
        lexed_chars   = 0;
        kinds_seen    = '0;
        tx_idle_en    = 1'b0;
        rx_idle_en    = 1'b0;
        rx_hold_req   = 1'b0;
        quiet_cycles  = 0;
        reset_lexer_model();

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_punctuation();
        test_number_edges();
        test_slash_and_bad();
        test_tab_column();
        test_end_in_comment();
        test_random_text();
        test_output_backpressure();
        test_drain_pause();
        test_tail_no_idle();
        wait_drained();

        $display("Sent %0d characters (%0d non-blank), checked %0d token beats, %0d kinds seen.",
                 chars_sent, lexed_chars, beats_checked, $countones(kinds_seen));
        $display("Covered edge-case text, random idling, output hold-off and a drain pause.");
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ spec_token_lexer.f @@
rtl/core/stl_pkg.sv
rtl/core/stl_lex_core.sv
rtl/core/stl_out_stage.sv
rtl/core/spec_token_lexer.sv
rtl/core/stl_checker.sv
tb/tb_top.sv
